>>> design/mstp_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the millisecond timer pool: request, status and kind codes,
// default sizes and the reset value of the tick rate register. No dependencies.
package mstp_pkg;

  localparam int NumSlotsDef = 32;
  localparam int MaxExpiries = 32;
  localparam int UsPerMs     = 1000;
  localparam int DivW        = 18;   // divisor width: up to 255 * 1000
  localparam logic [7:0] TicksPerUsReset = 8'd16;

  localparam logic [2:0] ReqPost     = 3'd0;
  localparam logic [2:0] ReqRestart  = 3'd1;
  localparam logic [2:0] ReqCancel   = 3'd2;
  localparam logic [2:0] ReqAdvance  = 3'd3;
  localparam logic [2:0] ReqComplete = 3'd4;
  localparam logic [2:0] ReqSetRef   = 3'd5;

  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StPoolFull  = 3'd1;
  localparam logic [2:0] StNotAlloc  = 3'd2;
  localparam logic [2:0] StPending   = 3'd3;
  localparam logic [2:0] StTickSame  = 3'd4;

  localparam logic KindAck    = 1'b0;
  localparam logic KindExpiry = 1'b1;

  localparam logic [2:0] CfgAddrTicksPerUs = 3'd0;

endpackage

>>> design/mstp_ifs.sv
`timescale 1ns / 1ps
// Request and result channel interfaces of the timer pool.
// Plain valid/ready channels; no package dependencies.
interface mstp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [4:0]  slot;
  logic [31:0] timeout_ms;
  logic signed [31:0] reload_ms;
  logic [31:0] now_tick;
  modport source (output valid, req_type, slot, timeout_ms, reload_ms, now_tick,
                  input ready);
  modport sink   (input valid, req_type, slot, timeout_ms, reload_ms, now_tick,
                  output ready);
endinterface

interface mstp_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [4:0]  result_slot;
  logic        nearest_valid;
  logic [4:0]  nearest_slot;
  logic [31:0] nearest_remaining;
  logic        last;
  modport source (output valid, kind, status, result_slot, nearest_valid, nearest_slot,
                  nearest_remaining, last, input ready);
  modport sink   (input valid, kind, status, result_slot, nearest_valid, nearest_slot,
                  nearest_remaining, last, output ready);
endinterface

>>> design/mstp_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mstp_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

>>> design/mstp_div.sv
`timescale 1ns / 1ps
// Restoring divider for a 32-bit dividend, one quotient bit per cycle.
// Depends on mstp_pkg for the divisor width.
module mstp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [31:0]                 dividend_i,
  input  logic [mstp_pkg::DivW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [31:0]                 quot_o,
  output logic [mstp_pkg::DivW-1:0]   rem_o
);
  logic                      busy_q, busy_d, done_q, done_d;
  logic [4:0]                cnt_q, cnt_d;
  logic [31:0]               a_q, a_d;
  logic [mstp_pkg::DivW-1:0] r_q, r_d, d_q, d_d;
  logic [mstp_pkg::DivW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    r_d    = r_q;
    d_d    = d_q;
    trial  = {r_q, a_q[31]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = dividend_i;
      r_d    = '0;
      d_d    = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, d_q}) begin
        r_d = mstp_pkg::DivW'(trial - {1'b0, d_q});
        a_d = {a_q[30:0], 1'b1};
      end else begin
        r_d = trial[mstp_pkg::DivW-1:0];
        a_d = {a_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
    d_q <= d_d;
  end

  assign done_o = done_q;
  assign quot_o = a_q;
  assign rem_o  = r_q;
endmodule

>>> design/multi_slot_timer_pool.sv
`timescale 1ns / 1ps
// Top level of the millisecond timer pool: sequencer, slot flags, slot RAMs, divider.
// Depends on mstp_pkg, mstp_ifs, mstp_ram and mstp_div.
//
//   channel  | direction | protocol       | beat
//   req_i    | in        | valid/ready    | one request
//   rsp_o    | out       | valid/ready    | one acknowledge or expiry event
//   apb      | in        | APB write/read | ticks_per_us at address 0
//
// Every request, whatever its kind, runs the nearest-timer scan, which reads
// the remaining-time RAM once per slot; a completion that reloads the stored period
// first reads it and writes it back as the remaining time. An advance adds two divisions
// (ticks by ticks_per_us*1000, then the leftover ticks by ticks_per_us), a read,
// write-back and apply step per slot, and one more division for each slot on its first
// decrement; all of this shares one bit-serial divider. rsp_o stalls hold the sequencer.
// A new request is taken while the last result still waits in the output register.
// Reset is asynchronous and active low; no clearing pass is needed.
module multi_slot_timer_pool #(
  parameter int NUM_SLOTS = mstp_pkg::NumSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mstp_req_if.sink    req_i,
  mstp_rsp_if.source  rsp_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SW-1:0] LastIdx = SW'(NUM_SLOTS - 1);

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_DIV_US  = 12'b000000000010,
    S_DIV_MS  = 12'b000000000100,
    S_RD      = 12'b000000001000,
    S_WB      = 12'b000000010000,
    S_DIVSLOT = 12'b000000100000,
    S_APPLY   = 12'b000001000000,
    S_C_RD    = 12'b000010000000,
    S_C_WB    = 12'b000100000000,
    S_NRD     = 12'b001000000000,
    S_NCMP    = 12'b010000000000,
    S_OUT     = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  logic [7:0]           tpu_q, tpu_d;
  logic [NUM_SLOTS-1:0] use_q, use_d, run_q, run_d, pend_q, pend_d, fired_q, fired_d;
  logic [5:0]           fcnt_q, fcnt_d;
  logic [SW-1:0]        idx_q, idx_d;
  logic [31:0]          ref_q, ref_d, now_q, now_d, upd_q, upd_d, dec_q, dec_d;
  logic [9:0]           left_q, left_d;
  logic [2:0]           status_q, status_d;
  logic [SW-1:0]        rslot_q, rslot_d;
  logic                 nv_q, nv_d;
  logic [SW-1:0]        ns_q, ns_d;
  logic [31:0]          nr_q, nr_d;

  logic                 ov_q, ov_d, okind_q, okind_d, olast_q, olast_d, onv_q, onv_d;
  logic [2:0]           ostat_q, ostat_d;
  logic [4:0]           oslot_q, oslot_d, ons_q, ons_d;
  logic [31:0]          onr_q, onr_d;

  logic                 we_rem, we_per, we_arm;
  logic [SW-1:0]        waddr;
  logic [31:0]          wd_rem, wd_per, rem_rd, per_rd, arm_rd;

  logic                 div_start, div_done;
  logic [31:0]          div_a, div_q;
  logic [mstp_pkg::DivW-1:0] div_b, div_r, rate, rate_k;

  logic                 free_found, slot_ok, alloc;
  logic [SW-1:0]        free_idx, si, low_idx;
  logic [31:0]          new_rem;
  logic [10:0]          lsum;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == mstp_pkg::CfgAddrTicksPerUs) ? {24'd0, tpu_q} : 32'd0;
  always_comb begin
    tpu_d = tpu_q;
    if (psel && penable && pwrite && paddr == mstp_pkg::CfgAddrTicksPerUs) begin
      tpu_d = pwdata[7:0];
    end
  end

  assign rate   = (tpu_q == 8'd0) ? mstp_pkg::DivW'(1) : mstp_pkg::DivW'(tpu_q);
  assign rate_k = mstp_pkg::DivW'(rate * mstp_pkg::DivW'(mstp_pkg::UsPerMs));

  assign si      = SW'(req_i.slot);
  assign slot_ok = 32'(req_i.slot) < NUM_SLOTS;
  assign alloc   = slot_ok && use_q[si];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!use_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  always_comb begin
    low_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (fired_q[i]) begin
        low_idx = SW'(i);
      end
    end
  end

  assign new_rem = (rem_rd > dec_q) ? rem_rd - dec_q : 32'd0;
  assign lsum    = 11'(left_q) + 11'(div_q[9:0]);
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    use_d    = use_q;
    run_d    = run_q;
    pend_d   = pend_q;
    fired_d  = fired_q;
    fcnt_d   = fcnt_q;
    idx_d    = idx_q;
    ref_d    = ref_q;
    now_d    = now_q;
    upd_d    = upd_q;
    dec_d    = dec_q;
    left_d   = left_q;
    status_d = status_q;
    rslot_d  = rslot_q;
    nv_d     = nv_q;
    ns_d     = ns_q;
    nr_d     = nr_q;
    ov_d     = ov_q && !rsp_o.ready;
    okind_d  = okind_q;
    olast_d  = olast_q;
    onv_d    = onv_q;
    ostat_d  = ostat_q;
    oslot_d  = oslot_q;
    ons_d    = ons_q;
    onr_d    = onr_q;
    we_rem   = 1'b0;
    we_per   = 1'b0;
    we_arm   = 1'b0;
    waddr    = idx_q;
    wd_rem   = new_rem;
    wd_per   = req_i.timeout_ms;
    div_start = 1'b0;
    div_a    = req_i.now_tick - ref_q;
    div_b    = rate;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          status_d = mstp_pkg::StOk;
          rslot_d  = '0;
          fired_d  = '0;
          fcnt_d   = '0;
          now_d    = req_i.now_tick;
          idx_d    = '0;
          nv_d     = 1'b0;
          ns_d     = '0;
          nr_d     = '0;
          state_d  = S_NRD;
          unique case (req_i.req_type)
            mstp_pkg::ReqPost: begin
              if (free_found) begin
                waddr  = free_idx;
                we_rem = 1'b1;
                we_per = 1'b1;
                we_arm = 1'b1;
                wd_rem = req_i.timeout_ms;
                use_d[free_idx]  = 1'b1;
                run_d[free_idx]  = 1'b0;
                pend_d[free_idx] = 1'b0;
                rslot_d = free_idx;
              end else begin
                status_d = mstp_pkg::StPoolFull;
              end
            end
            mstp_pkg::ReqRestart: begin
              if (alloc) begin
                waddr  = si;
                we_rem = 1'b1;
                we_per = 1'b1;
                wd_rem = req_i.timeout_ms;
              end else begin
                status_d = mstp_pkg::StNotAlloc;
              end
            end
            mstp_pkg::ReqCancel: begin
              if (!alloc) begin
                status_d = mstp_pkg::StNotAlloc;
              end else if (pend_q[si]) begin
                status_d = mstp_pkg::StPending;
              end else begin
                use_d[si] = 1'b0;
                run_d[si] = 1'b0;
              end
            end
            mstp_pkg::ReqAdvance: begin
              if (req_i.now_tick == ref_q) begin
                status_d = mstp_pkg::StTickSame;
              end else begin
                div_start = 1'b1;
                div_b     = rate_k;
                state_d   = S_DIV_US;
              end
            end
            mstp_pkg::ReqComplete: begin
              if (!alloc || !pend_q[si]) begin
                status_d = mstp_pkg::StNotAlloc;
              end else if (req_i.reload_ms[31]) begin
                use_d[si]  = 1'b0;
                run_d[si]  = 1'b0;
                pend_d[si] = 1'b0;
              end else if (req_i.reload_ms != 32'sd0) begin
                waddr  = si;
                we_rem = 1'b1;
                we_per = 1'b1;
                wd_rem = req_i.reload_ms;
                wd_per = req_i.reload_ms;
                pend_d[si] = 1'b0;
              end else begin
                // Reload from the stored period: read it first.
                idx_d   = si;
                state_d = S_C_RD;
              end
            end
            mstp_pkg::ReqSetRef: begin
              ref_d  = req_i.now_tick;
              left_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_DIV_US: begin
        if (div_done) begin
          // Whole milliseconds come from the quotient; the leftover ticks
          // still hold the sub-millisecond part, counted in ticks.
          upd_d     = div_q;
          div_start = 1'b1;
          div_a     = 32'(div_r);
          div_b     = rate;
          state_d   = S_DIV_MS;
        end
      end
      S_DIV_MS: begin
        if (div_done) begin
          if (lsum >= 11'(mstp_pkg::UsPerMs)) begin
            upd_d  = upd_q + 32'd1;
            left_d = 10'(lsum - 11'(mstp_pkg::UsPerMs));
          end else begin
            upd_d  = upd_q;
            left_d = lsum[9:0];
          end
          ref_d   = now_q;
          idx_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: state_d = S_WB;
      S_WB: begin
        if (use_q[idx_q] && upd_q != 32'd0 && !run_q[idx_q]) begin
          // First decrement counts from the slot's own arm tick.
          run_d[idx_q] = 1'b1;
          div_start    = 1'b1;
          div_a        = now_q - arm_rd;
          div_b        = rate_k;
          state_d      = S_DIVSLOT;
        end else begin
          dec_d   = (use_q[idx_q] && upd_q != 32'd0) ? upd_q : 32'd0;
          state_d = S_APPLY;
        end
      end
      S_DIVSLOT: begin
        if (div_done) begin
          dec_d   = div_q;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        we_rem = 1'b1;
        if (use_q[idx_q] && !pend_q[idx_q] && new_rem == 32'd0 &&
            fcnt_q < 6'(mstp_pkg::MaxExpiries)) begin
          pend_d[idx_q]  = 1'b1;
          fired_d[idx_q] = 1'b1;
          fcnt_d         = fcnt_q + 6'd1;
        end
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = S_NRD;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = S_RD;
        end
      end
      S_C_RD: state_d = S_C_WB;
      S_C_WB: begin
        we_rem = 1'b1;
        wd_rem = per_rd;
        pend_d[idx_q] = 1'b0;
        idx_d   = '0;
        state_d = S_NRD;
      end
      S_NRD: state_d = S_NCMP;
      S_NCMP: begin
        if (use_q[idx_q] && (!nv_q || rem_rd < nr_q)) begin
          nv_d = 1'b1;
          ns_d = idx_q;
          nr_d = rem_rd;
        end
        if (idx_q == LastIdx) begin
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = S_NRD;
        end
      end
      S_OUT: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d  = 1'b1;
          onv_d = nv_q;
          ons_d = 5'(ns_q);
          onr_d = nr_q;
          if (fired_q != '0) begin
            okind_d = mstp_pkg::KindExpiry;
            ostat_d = mstp_pkg::StOk;
            oslot_d = 5'(low_idx);
            olast_d = 1'b0;
            fired_d[low_idx] = 1'b0;
          end else begin
            okind_d = mstp_pkg::KindAck;
            ostat_d = status_q;
            oslot_d = 5'(rslot_q);
            olast_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tpu_q   <= mstp_pkg::TicksPerUsReset;
      use_q   <= '0;
      run_q   <= '0;
      pend_q  <= '0;
      fired_q <= '0;
      fcnt_q  <= '0;
      idx_q   <= '0;
      ref_q   <= '0;
      left_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tpu_q   <= tpu_d;
      use_q   <= use_d;
      run_q   <= run_d;
      pend_q  <= pend_d;
      fired_q <= fired_d;
      fcnt_q  <= fcnt_d;
      idx_q   <= idx_d;
      ref_q   <= ref_d;
      left_q  <= left_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    upd_q    <= upd_d;
    dec_q    <= dec_d;
    status_q <= status_d;
    rslot_q  <= rslot_d;
    nv_q     <= nv_d;
    ns_q     <= ns_d;
    nr_q     <= nr_d;
    okind_q  <= okind_d;
    olast_q  <= olast_d;
    onv_q    <= onv_d;
    ostat_q  <= ostat_d;
    oslot_q  <= oslot_d;
    ons_q    <= ons_d;
    onr_q    <= onr_d;
  end

  assign rsp_o.valid             = ov_q;
  assign rsp_o.kind              = okind_q;
  assign rsp_o.status            = ostat_q;
  assign rsp_o.result_slot       = oslot_q;
  assign rsp_o.nearest_valid     = onv_q;
  assign rsp_o.nearest_slot      = ons_q;
  assign rsp_o.nearest_remaining = onr_q;
  assign rsp_o.last              = olast_q;

  mstp_ram #(.Width(32), .Depth(NUM_SLOTS)) u_rem_ram (
    .clk_i, .we_i(we_rem), .waddr_i(waddr), .wdata_i(wd_rem), .raddr_i(idx_q),
    .rdata_o(rem_rd)
  );
  mstp_ram #(.Width(32), .Depth(NUM_SLOTS)) u_per_ram (
    .clk_i, .we_i(we_per), .waddr_i(waddr), .wdata_i(wd_per), .raddr_i(idx_q),
    .rdata_o(per_rd)
  );
  mstp_ram #(.Width(32), .Depth(NUM_SLOTS)) u_arm_ram (
    .clk_i, .we_i(we_arm), .waddr_i(waddr), .wdata_i(req_i.now_tick), .raddr_i(idx_q),
    .rdata_o(arm_rd)
  );

  mstp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q), .rem_o(div_r)
  );
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the millisecond timer pool: a queue-fed request driver,
// a result monitor and a behavioral predictor of the slot pool.
// Depends on mstp_pkg, mstp_ifs and the multi_slot_timer_pool RTL.
module testbench;

  localparam int NSLOT = 32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [4:0]  slot;
    logic [31:0] timeout_ms;
    logic [31:0] reload_ms;
    logic [31:0] now_tick;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [4:0]  result_slot;
    logic        nearest_valid;
    logic [4:0]  nearest_slot;
    logic [31:0] nearest_remaining;
    logic        last;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  mstp_req_if req_ch ();
  mstp_rsp_if rsp_ch ();

  multi_slot_timer_pool dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_ch.sink), .rsp_o(rsp_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Pool model state.
  logic [7:0]  tick_rate;
  logic        in_use  [NSLOT];
  logic [31:0] remain  [NSLOT];
  logic [31:0] period  [NSLOT];
  logic        started [NSLOT];
  logic [31:0] arm_tick[NSLOT];
  logic        pending [NSLOT];
  logic [31:0] ref_tick;
  logic [31:0] carry_us;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int   errors = 0;
  int   send_idle_pct = 8, recv_idle_pct = 69;
  bit   recv_hold = 1'b0;
  int   quiet_cycles = 0;
  logic [31:0] tick_now = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [31:0] ticks_to_us(input logic [31:0] t);
    logic [31:0] r;
    r = (tick_rate == 0) ? 32'd1 : {24'd0, tick_rate};
    return t / r;
  endfunction

  function automatic void free_slot(input int s);
    in_use[s] = 0; remain[s] = 0; period[s] = 0;
    started[s] = 0; arm_tick[s] = 0; pending[s] = 0;
  endfunction

  function automatic void predict_pool(input req_t r);
    rsp_t acc[$];
    rsp_t x;
    logic [2:0] st;
    logic [4:0] rs;
    logic [31:0] el, upd, dec, nr;
    logic [4:0] ns;
    logic nv;
    bit alloc;
    int fired;
    st = mstp_pkg::StOk; rs = 0; fired = 0;
    alloc = in_use[r.slot];
    x = '0;
    case (r.req_type)
      mstp_pkg::ReqPost: begin
        st = mstp_pkg::StPoolFull;
        for (int s = 0; s < NSLOT; s++) begin
          if (!in_use[s]) begin
            free_slot(s);
            in_use[s] = 1; period[s] = r.timeout_ms; remain[s] = r.timeout_ms;
            arm_tick[s] = r.now_tick; st = mstp_pkg::StOk; rs = 5'(s);
            break;
          end
        end
      end
      mstp_pkg::ReqRestart: begin
        if (!alloc) st = mstp_pkg::StNotAlloc;
        else begin
          period[r.slot] = r.timeout_ms; remain[r.slot] = r.timeout_ms;
        end
      end
      mstp_pkg::ReqCancel: begin
        if (!alloc) st = mstp_pkg::StNotAlloc;
        else if (pending[r.slot]) st = mstp_pkg::StPending;
        else free_slot(r.slot);
      end
      mstp_pkg::ReqAdvance: begin
        if (r.now_tick == ref_tick) st = mstp_pkg::StTickSame;
        else begin
          el = ticks_to_us(r.now_tick - ref_tick);
          ref_tick = r.now_tick;
          upd = el / 1000;
          carry_us = carry_us + el % 1000;
          upd = upd + carry_us / 1000;
          carry_us = carry_us % 1000;
          if (upd != 0) begin
            for (int s = 0; s < NSLOT; s++) begin
              if (in_use[s]) begin
                if (started[s]) dec = upd;
                else begin
                  dec = ticks_to_us(r.now_tick - arm_tick[s]) / 1000;
                  started[s] = 1;
                end
                remain[s] = (remain[s] > dec) ? remain[s] - dec : 0;
              end
            end
          end
          for (int s = 0; s < NSLOT && fired < mstp_pkg::MaxExpiries; s++) begin
            if (in_use[s] && !pending[s] && remain[s] == 0) begin
              pending[s] = 1;
              x = '0; x.kind = mstp_pkg::KindExpiry; x.status = mstp_pkg::StOk;
              x.result_slot = 5'(s);
              acc.push_back(x);
              fired++;
            end
          end
        end
      end
      mstp_pkg::ReqComplete: begin
        if (!alloc || !pending[r.slot]) st = mstp_pkg::StNotAlloc;
        else if (r.reload_ms[31]) free_slot(r.slot);
        else begin
          if (r.reload_ms != 0) period[r.slot] = r.reload_ms;
          remain[r.slot] = period[r.slot];
          pending[r.slot] = 0;
        end
      end
      mstp_pkg::ReqSetRef: begin
        ref_tick = r.now_tick; carry_us = 0;
      end
      default: ;
    endcase
    x = '0; x.kind = mstp_pkg::KindAck; x.status = st; x.result_slot = rs;
    acc.push_back(x);
    nv = 0; ns = 0; nr = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (in_use[s] && (!nv || remain[s] < nr)) begin
        nv = 1; ns = 5'(s); nr = remain[s];
      end
    end
    foreach (acc[k]) begin
      acc[k].nearest_valid = nv;
      acc[k].nearest_slot = ns;
      acc[k].nearest_remaining = nr;
      acc[k].last = (k == acc.size() - 1);
      expected_rsps.push_back(acc[k]);
    end
  endfunction

  // Request driver.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
      req_ch.req_type <= '0; req_ch.slot <= '0; req_ch.timeout_ms <= '0;
      req_ch.reload_ms <= '0; req_ch.now_tick <= '0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_pool({req_ch.req_type, req_ch.slot, req_ch.timeout_ms,
                      req_ch.reload_ms, req_ch.now_tick});
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          req_t r;
          r = pending_reqs.pop_front();
          req_ch.valid <= 1'b1;
          {req_ch.req_type, req_ch.slot, req_ch.timeout_ms,
           req_ch.reload_ms, req_ch.now_tick} <= r;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected beat", 0, 0);
        end else begin
          rsp_t w;
          w = expected_rsps.pop_front();
          if (rsp_ch.kind !== w.kind) report("kind", rsp_ch.kind, w.kind);
          if (rsp_ch.status !== w.status) report("status", rsp_ch.status, w.status);
          if (rsp_ch.result_slot !== w.result_slot)
            report("result_slot", rsp_ch.result_slot, w.result_slot);
          if (rsp_ch.nearest_valid !== w.nearest_valid)
            report("nearest_valid", rsp_ch.nearest_valid, w.nearest_valid);
          if (rsp_ch.nearest_slot !== w.nearest_slot)
            report("nearest_slot", rsp_ch.nearest_slot, w.nearest_slot);
          if (rsp_ch.nearest_remaining !== w.nearest_remaining)
            report("nearest_remaining", rsp_ch.nearest_remaining, w.nearest_remaining);
          if (rsp_ch.last !== w.last) report("last", rsp_ch.last, w.last);
        end
      end
      rsp_ch.ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_tick_rate(input logic [7:0] rate);
    apb_write(mstp_pkg::CfgAddrTicksPerUs, {24'd0, rate});
    tick_rate = rate;
  endtask

  task automatic add_req(input logic [2:0] t, input logic [4:0] s, input logic [31:0] tmo,
                         input logic [31:0] nt, input logic [31:0] now);
    pending_reqs.push_back({t, s, tmo, nt, now});
  endtask

  // Moves the tick count up to 50000 ticks ahead, or now and then to a random value, so periodic timers actually fire.
  task automatic add_random_req();
    logic [2:0] t;
    int pick;
    logic [31:0] tmo, nt;
    pick = $urandom_range(99);
    if (pick < 25) t = mstp_pkg::ReqPost;
    else if (pick < 35) t = mstp_pkg::ReqRestart;
    else if (pick < 43) t = mstp_pkg::ReqCancel;
    else if (pick < 73) t = mstp_pkg::ReqAdvance;
    else if (pick < 93) t = mstp_pkg::ReqComplete;
    else if (pick < 97) t = mstp_pkg::ReqSetRef;
    else t = 3'($urandom_range(7));
    tmo = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(12);
    case ($urandom_range(3))
      0: nt = 32'hFFFF_FFFF - $urandom_range(5);
      1: nt = 0;
      2: nt = $urandom_range(10);
      default: nt = $urandom();
    endcase
    if ($urandom_range(15) != 0) tick_now = tick_now + $urandom_range(50000);
    else if ($urandom_range(1)) tick_now = $urandom();
    add_req(t, 5'($urandom_range(NSLOT - 1)), tmo, nt, tick_now);
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  initial begin
    tick_rate = mstp_pkg::TicksPerUsReset;
    for (int s = 0; s < NSLOT; s++) free_slot(s);
    ref_tick = 0; carry_us = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: edges of every request kind.
    set_tick_rate(8'd0);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 0);
    add_req(mstp_pkg::ReqPost, 0, 0, 0, 0);
    add_req(mstp_pkg::ReqPost, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    add_req(mstp_pkg::ReqPost, 0, 3, 0, 100);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 1500);
    add_req(mstp_pkg::ReqCancel, 0, 0, 0, 0);
    add_req(mstp_pkg::ReqRestart, 0, 7, 0, 0);
    add_req(mstp_pkg::ReqComplete, 0, 0, 32'd0, 0);
    add_req(mstp_pkg::ReqComplete, 0, 0, 32'd0, 0);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 1500);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 1800);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 9000);
    add_req(mstp_pkg::ReqComplete, 0, 0, 32'h7FFF_FFFF, 0);
    add_req(mstp_pkg::ReqComplete, 2, 0, 32'h8000_0000, 0);
    add_req(mstp_pkg::ReqCancel, 31, 0, 0, 0);
    add_req(mstp_pkg::ReqRestart, 31, 5, 0, 0);
    add_req(mstp_pkg::ReqSetRef, 31, 0, 0, 32'hFFFF_FFF0);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 32'h0000_2000);
    add_req(3'd6, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(3'd7, 0, 0, 0, 0);
    drain();

    // Fill the pool so that one advance causes many expiries.
    set_tick_rate(8'd255);
    add_req(mstp_pkg::ReqSetRef, 0, 0, 0, 0);
    for (int i = 0; i < 33; i++) add_req(mstp_pkg::ReqPost, 0, 0, 0, 0);
    recv_hold = 1'b1;
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 10);
    add_req(mstp_pkg::ReqSetRef, 0, 0, 0, 20);
    add_req(mstp_pkg::ReqAdvance, 0, 0, 0, 30);
    repeat (3000) @(posedge clk_i);
    recv_hold = 1'b0;
    for (int s = 0; s < NSLOT; s++) begin
      add_req(mstp_pkg::ReqComplete, 5'(s), 0, 32'hFFFF_FFFF, 0);
    end
    drain();

    tick_now = 0;
    send_idle_pct = 8; recv_idle_pct = 69;
    set_tick_rate(8'd1);
    add_req(mstp_pkg::ReqSetRef, 0, 0, 0, 0);
    for (int i = 0; i < 14; i++) add_random_req();
    drain();
    send_idle_pct = 69; recv_idle_pct = 8;
    set_tick_rate(8'd16);
    for (int i = 0; i < 14; i++) add_random_req();
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_tick_rate(8'($urandom_range(2, 254)));
    for (int i = 0; i < 14; i++) add_random_req();
    drain();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
